>>> hdl/stable_sorted_insert_top_n_macros.svh
// Assertion macros shared by the stable sorted insert block.
`ifndef STABLE_SORTED_INSERT_TOP_N_MACROS_SVH
`define STABLE_SORTED_INSERT_TOP_N_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define SSI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssi assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define SSI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssi assertion failed");
`else
`define SSI_ASSERT_IMP(label, ante, cons)
`define SSI_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hdl/ssi_pkg.sv
// Shared codes, types and key helpers for the stable sorted insert block.
`timescale 1ns / 1ps
package ssi_pkg;

    // request commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_EMIT   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_EMIT   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_NODATA = 2'd2;

    // per-cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_ROTATE = 2'd2;
    localparam logic [1:0] CELL_CLEAR  = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DESC  = 2'd0;
    localparam logic [1:0] REG_KSEL  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    // key select codes
    localparam logic [1:0] KEY_NOW  = 2'd0;
    localparam logic [1:0] KEY_MID  = 2'd1;
    localparam logic [1:0] KEY_LONG = 2'd2;

    // emit count limit
    localparam logic [6:0] LIST_MAX = 7'd64;

    // sort configuration seen by every cell
    typedef struct packed {
        logic       desc;
        logic [1:0] ksel;
    } ssi_cfg_t;

    // sequencer controls toward the cell row and output register
    typedef struct packed {
        logic [1:0] op;
        logic       emit;
        logic [1:0] status;
        logic       last;
        logic       idle;
    } ssi_seq_t;

    // pick the sort key out of the three loads; unused code acts as current load
    function automatic logic [31:0] key_pick(input logic [1:0] ksel, input logic [31:0] a,
                                             input logic [31:0] b, input logic [31:0] c);
        logic [31:0] k;
        unique case (ksel)
            KEY_MID:  k = b;
            KEY_LONG: k = c;
            default:  k = a;
        endcase
        return k;
    endfunction

    // true when key a ranks strictly ahead of key b
    function automatic logic key_ahead(input logic desc, input logic [31:0] a,
                                       input logic [31:0] b);
        return desc ? (a > b) : (a < b);
    endfunction

endpackage

>>> hdl/ssi_req_if.sv
// Request channel: command and entry payload with valid/ready.
`timescale 1ns / 1ps
interface ssi_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] host_id;
    logic [23:0] load_now;
    logic [23:0] load_mid;
    logic [23:0] load_long;
    logic [15:0] random_fraction;

    modport source (
        output valid, command, host_id, load_now, load_mid, load_long, random_fraction,
        input  ready
    );
    modport sink (
        input  valid, command, host_id, load_now, load_mid, load_long, random_fraction,
        output ready
    );
endinterface

>>> hdl/ssi_rsp_if.sv
// Result channel: status and emitted entry with valid/ready.
`timescale 1ns / 1ps
interface ssi_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_host;
    logic [23:0] out_now;
    logic [23:0] out_mid;
    logic [23:0] out_long;
    logic        last_result;

    modport source (
        output valid, status, out_host, out_now, out_mid, out_long, last_result,
        input  ready
    );
    modport sink (
        input  valid, status, out_host, out_now, out_mid, out_long, last_result,
        output ready
    );
endinterface

>>> hdl/ssi_cell.sv
// One list cell: holds an entry, compares, inserts, shifts, rotates and clears.
`timescale 1ns / 1ps
module ssi_cell #(
    parameter int LOAD_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssi_pkg::ssi_cfg_t             cfg,
    input  logic [1:0]                    op,
    input  logic                          found_in,
    output logic                          found_out,
    output logic                          take,
    input  logic [15:0]                   new_id,
    input  logic [2:0][LOAD_BITS-1:0]     new_loads,
    input  logic                          prev_valid,
    input  logic [15:0]                   prev_id,
    input  logic [2:0][LOAD_BITS-1:0]     prev_loads,
    input  logic                          next_valid,
    input  logic [15:0]                   next_id,
    input  logic [2:0][LOAD_BITS-1:0]     next_loads,
    input  logic [15:0]                   head_id,
    input  logic [2:0][LOAD_BITS-1:0]     head_loads,
    output logic                          valid,
    output logic [15:0]                   id,
    output logic [2:0][LOAD_BITS-1:0]     loads
);
    import ssi_pkg::*;

    logic                      valid_reg, valid_next;
    logic [15:0]               id_reg, id_next;
    logic [2:0][LOAD_BITS-1:0] loads_reg, loads_next;
    logic [31:0]               my_key, new_key;

    // new entry goes here or earlier when it ranks ahead, or the cell is empty
    always_comb
    begin
        my_key    = key_pick(cfg.ksel, 32'(loads_reg[0]), 32'(loads_reg[1]),
                             32'(loads_reg[2]));
        new_key   = key_pick(cfg.ksel, 32'(new_loads[0]), 32'(new_loads[1]),
                             32'(new_loads[2]));
        take      = !valid_reg || key_ahead(cfg.desc, new_key, my_key);
        found_out = found_in || take;
    end

    // next contents
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        loads_next = loads_reg;
        unique case (op)
            CELL_INSERT:
            begin
                if (found_in)
                begin
                    valid_next = prev_valid;
                    id_next    = prev_id;
                    loads_next = prev_loads;
                end
                else if (take)
                begin
                    valid_next = 1'b1;
                    id_next    = new_id;
                    loads_next = new_loads;
                end
            end
            CELL_ROTATE:
            begin
                // valid prefix turns as a ring: the last valid cell takes the head
                if (next_valid)
                begin
                    id_next    = next_id;
                    loads_next = next_loads;
                end
                else
                begin
                    id_next    = head_id;
                    loads_next = head_loads;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        loads_reg <= loads_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign loads = loads_reg;

endmodule

>>> hdl/ssi_ctrl.sv
// Sequencer: entry count, emit passes over the ring and tie pick.
`timescale 1ns / 1ps
module ssi_ctrl #(
    parameter int MAX_ENTRIES = 32,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [1:0]        cmd,
    input  logic [15:0]       frac,
    input  logic              ins_ok,
    input  logic [6:0]        list_count,
    input  logic              out_free,
    input  logic [31:0]       head_key,
    output ssi_pkg::ssi_seq_t seq,
    output logic [CW-1:0]     total
);
    import ssi_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROT  = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_PICK = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] ties_reg, ties_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic          run_reg, run_next;
    logic          pmode_reg, pmode_next;
    logic [31:0]   key0_reg, key0_next;
    logic [15:0]   frac_reg, frac_next;
    logic [6:0]    want;
    logic [CW+15:0] prod;
    logic          pass_end;

    always_comb
    begin
        // clamp the emit count to 1..64
        if (list_count == 7'd0)
            want = 7'd1;
        else if (list_count > LIST_MAX)
            want = LIST_MAX;
        else
            want = list_count;

        prod     = (CW + 16)'(ties_reg) * (CW + 16)'(frac_reg);
        pass_end = (step_reg == total_reg - CW'(1));

        state_next = state_reg;
        total_next = total_reg;
        step_next  = step_reg;
        n_next     = n_reg;
        ties_next  = ties_reg;
        pick_next  = pick_reg;
        run_next   = run_reg;
        pmode_next = pmode_reg;
        key0_next  = key0_reg;
        frac_next  = frac_reg;

        seq        = '0;
        seq.op     = CELL_HOLD;
        seq.idle   = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                seq.op = CELL_INSERT;
                                if (total_reg != CW'(MAX_ENTRIES))
                                    total_next = total_reg + CW'(1);
                            end
                            seq.emit   = 1'b1;
                            seq.status = ST_NODATA;
                            seq.last   = 1'b1;
                        end
                        CMD_EMIT:
                        begin
                            if (total_reg == '0)
                            begin
                                seq.emit   = 1'b1;
                                seq.status = ST_EMPTY;
                                seq.last   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ROT;
                                step_next  = '0;
                                pmode_next = (want == 7'd1);
                                frac_next  = frac;
                                if (want < 7'(total_reg))
                                    n_next = CW'(want);
                                else
                                    n_next = total_reg;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            seq.op     = CELL_CLEAR;
                            total_next = '0;
                            seq.emit   = 1'b1;
                            seq.status = ST_NODATA;
                            seq.last   = 1'b1;
                        end
                        default:
                        begin
                            seq.emit   = 1'b1;
                            seq.status = ST_NODATA;
                            seq.last   = 1'b1;
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                if (out_free)
                begin
                    seq.op = CELL_ROTATE;
                    if (!pmode_reg)
                    begin
                        // emit the head while the first n entries pass by
                        if (step_reg < n_reg)
                        begin
                            seq.emit   = 1'b1;
                            seq.status = ST_EMIT;
                            seq.last   = (step_reg == n_reg - CW'(1));
                        end
                    end
                    else if (step_reg == '0)
                    begin
                        key0_next = head_key;
                        ties_next = CW'(1);
                        run_next  = 1'b1;
                    end
                    else if (run_reg && head_key == key0_reg)
                    begin
                        ties_next = ties_reg + CW'(1);
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end
                    step_next = step_reg + CW'(1);
                    if (pass_end)
                    begin
                        step_next  = '0;
                        state_next = pmode_reg ? S_CALC : S_IDLE;
                    end
                end
            end
            S_CALC:
            begin
                // index among ties = (ties * fraction) >> 16
                pick_next  = prod[CW+15:16];
                state_next = S_PICK;
            end
            S_PICK:
            begin
                if (out_free)
                begin
                    seq.op = CELL_ROTATE;
                    if (step_reg == pick_reg)
                    begin
                        seq.emit   = 1'b1;
                        seq.status = ST_EMIT;
                        seq.last   = 1'b1;
                    end
                    step_next = step_reg + CW'(1);
                    if (pass_end)
                    begin
                        step_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            step_reg  <= '0;
            run_reg   <= 1'b0;
            pmode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            step_reg  <= step_next;
            run_reg   <= run_next;
            pmode_reg <= pmode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        ties_reg <= ties_next;
        pick_reg <= pick_next;
        key0_reg <= key0_next;
        frac_reg <= frac_next;
    end

    assign total = total_reg;

endmodule

>>> hdl/stable_sorted_insert_top_n.sv
// Top level: stable sorted top-N list built as a row of compare-and-shift cells.
// Insert, clear, empty emit: done on acceptance; the status result is registered next cycle.
// Emit, count above 1: accept, then one ring pass over the T entries held; the first result
// comes from S_ROT after the accept, then one per ring step for the first N.
// Tie pick, count 0 or 1: accept, tie-count pass, multiply step (S_CALC), pick pass.
// Output stalls hold the ring. rst_n resets config and clears the list and output valid at once.
`timescale 1ns / 1ps
`include "stable_sorted_insert_top_n_macros.svh"
module stable_sorted_insert_top_n #(
    parameter int MAX_ENTRIES = 32,
    parameter int LOAD_BITS   = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ssi_req_if.sink     in_ch,
    ssi_rsp_if.source   out_ch
);
    import ssi_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // configuration registers
    logic       desc_reg, desc_next;
    logic [1:0] ksel_reg, ksel_next;
    logic [6:0] count_reg, count_next;
    logic       cfg_wr;
    ssi_cfg_t   cfg;

    // cell row
    logic [MAX_ENTRIES-1:0]    valid_vec;
    logic [MAX_ENTRIES-1:0]    take_vec;
    logic [MAX_ENTRIES:0]      found;
    logic [15:0]               id_arr    [MAX_ENTRIES];
    logic [2:0][LOAD_BITS-1:0] loads_arr [MAX_ENTRIES];
    logic [2:0][LOAD_BITS-1:0] new_loads;
    logic [31:0]               wide_in   [3];
    logic [31:0]               head_w    [3];
    logic [31:0]               head_key;

    // sequencer
    ssi_seq_t      seq;
    logic [CW-1:0] total;
    logic          in_fire;
    logic          out_free;
    logic          ins_ok;
    logic          empty_emit;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic        last_reg, last_next;
    logic [15:0] host_reg, host_next;
    logic [23:0] now_reg, now_next;
    logic [23:0] mid_reg, mid_next;
    logic [23:0] long_reg, long_next;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        desc_next  = desc_reg;
        ksel_next  = ksel_reg;
        count_next = count_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DESC:  desc_next  = pwdata[0];
                REG_KSEL:  ksel_next  = pwdata[1:0];
                REG_COUNT: count_next = pwdata[6:0];
                default:   desc_next  = desc_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DESC:  prdata = {31'd0, desc_reg};
            REG_KSEL:  prdata = {30'd0, ksel_reg};
            REG_COUNT: prdata = {25'd0, count_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg  <= 1'b0;
            ksel_reg  <= KEY_NOW;
            count_reg <= 7'd1;
        end
        else
        begin
            desc_reg  <= desc_next;
            ksel_reg  <= ksel_next;
            count_reg <= count_next;
        end
    end

    assign cfg.desc = desc_reg;
    assign cfg.ksel = ksel_reg;

    // incoming loads trimmed or widened to the stored width
    always_comb
    begin
        wide_in[0]   = 32'(in_ch.load_now);
        wide_in[1]   = 32'(in_ch.load_mid);
        wide_in[2]   = 32'(in_ch.load_long);
        new_loads[0] = wide_in[0][LOAD_BITS-1:0];
        new_loads[1] = wide_in[1][LOAD_BITS-1:0];
        new_loads[2] = wide_in[2][LOAD_BITS-1:0];
    end

    // row of cells; the insert point is the first cell that takes
    assign found[0] = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic                      p_valid, n_valid;
        logic [15:0]               p_id, n_id;
        logic [2:0][LOAD_BITS-1:0] p_loads, n_loads;

        if (i == 0)
        begin : g_first
            assign p_valid = 1'b0;
            assign p_id    = id_arr[0];
            assign p_loads = loads_arr[0];
        end
        else
        begin : g_mid
            assign p_valid = valid_vec[i-1];
            assign p_id    = id_arr[i-1];
            assign p_loads = loads_arr[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign n_valid = 1'b0;
            assign n_id    = id_arr[0];
            assign n_loads = loads_arr[0];
        end
        else
        begin : g_inner
            assign n_valid = valid_vec[i+1];
            assign n_id    = id_arr[i+1];
            assign n_loads = loads_arr[i+1];
        end

        ssi_cell #(
            .LOAD_BITS (LOAD_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (cfg),
            .op         (seq.op),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .take       (take_vec[i]),
            .new_id     (in_ch.host_id),
            .new_loads  (new_loads),
            .prev_valid (p_valid),
            .prev_id    (p_id),
            .prev_loads (p_loads),
            .next_valid (n_valid),
            .next_id    (n_id),
            .next_loads (n_loads),
            .head_id    (id_arr[0]),
            .head_loads (loads_arr[0]),
            .valid      (valid_vec[i]),
            .id         (id_arr[i]),
            .loads      (loads_arr[i])
        );
    end

    // a full list only admits a key strictly ahead of the tail
    assign ins_ok = take_vec[MAX_ENTRIES-1];

    always_comb
    begin
        head_w[0] = 32'(loads_arr[0][0]);
        head_w[1] = 32'(loads_arr[0][1]);
        head_w[2] = 32'(loads_arr[0][2]);
        head_key  = key_pick(ksel_reg, head_w[0], head_w[1], head_w[2]);
    end

    // handshake
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = seq.idle && out_free;
    assign in_fire     = in_ch.valid && in_ch.ready;

    ssi_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .cmd        (in_ch.command),
        .frac       (in_ch.random_fraction),
        .ins_ok     (ins_ok),
        .list_count (count_reg),
        .out_free   (out_free),
        .head_key   (head_key),
        .seq        (seq),
        .total      (total)
    );

    // output register: head entry for emitted results, zeros otherwise
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        host_next      = host_reg;
        now_next       = now_reg;
        mid_next       = mid_reg;
        long_next      = long_reg;
        if (out_ch.ready)
            out_valid_next = 1'b0;
        if (seq.emit)
        begin
            out_valid_next = 1'b1;
            status_next    = seq.status;
            last_next      = seq.last;
            if (seq.status == ST_EMIT)
            begin
                host_next = id_arr[0];
                now_next  = head_w[0][23:0];
                mid_next  = head_w[1][23:0];
                long_next = head_w[2][23:0];
            end
            else
            begin
                host_next = '0;
                now_next  = '0;
                mid_next  = '0;
                long_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        last_reg   <= last_next;
        host_reg   <= host_next;
        now_reg    <= now_next;
        mid_reg    <= mid_next;
        long_reg   <= long_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.last_result = last_reg;
    assign out_ch.out_host    = host_reg;
    assign out_ch.out_now     = now_reg;
    assign out_ch.out_mid     = mid_reg;
    assign out_ch.out_long    = long_reg;

    // checks
    assign empty_emit = in_fire && in_ch.command == CMD_EMIT && total == '0;

    `SSI_ASSERT_IMP(a_count_match, 1'b1, $countones(valid_vec) == int'(total))
    `SSI_ASSERT_IMP(a_more_pending, out_ch.valid && !out_ch.last_result, !seq.idle)
    `SSI_ASSERT_NXT(a_empty_status, empty_emit, out_ch.valid && out_ch.status == ST_EMPTY)
    `SSI_ASSERT_IMP(a_emit_has_data, out_ch.valid && out_ch.status == ST_EMIT, total != '0)

endmodule
